@@ src/kvt_pkg.sv @@
`default_nettype none

package kvt_pkg;

    // Default buffer size in bytes; offsets never go past 4095 whatever it is.
    localparam int KVT_BUFFER_BYTES_DEFAULT = 4096;

    localparam int POS_W  = 13;
    localparam int OFS_W  = 12;
    localparam int LINE_W = 16;

    localparam logic [7:0] CH_BLANK = 8'h20;
    localparam logic [7:0] CH_TAB   = 8'h09;
    localparam logic [7:0] CH_EQ    = 8'h3D;
    localparam logic [7:0] CH_EOL   = 8'h0A;
    localparam logic [7:0] CH_QUOTE = 8'h22;
    localparam logic [7:0] CH_NUL   = 8'h00;

    typedef enum logic [2:0] {
        MODE_SKIP,
        MODE_WORD,
        MODE_QFIRST,
        MODE_QBODY
    } scan_mode_t;

    typedef struct packed {
        logic [POS_W-1:0]  byte_position;
        logic [LINE_W-1:0] line_count;
        scan_mode_t        scan_mode;
        logic [OFS_W-1:0]  token_begin;
        logic [LINE_W-1:0] token_line;
        logic              previous_was_quote;
        logic              pending_quote;
        logic [OFS_W-1:0]  saved_key_offset;
        logic [OFS_W-1:0]  saved_key_length;
        logic              expect_value;
        logic              error_seen;
    } kvt_state_t;

    typedef struct packed {
        logic              pair_valid;
        logic [OFS_W-1:0]  key_offset;
        logic [OFS_W-1:0]  key_length;
        logic [OFS_W-1:0]  value_offset;
        logic [OFS_W-1:0]  value_length;
        logic [LINE_W-1:0] line_number;
        logic              buffer_end;
        logic              had_error;
    } kvt_result_t;

    localparam kvt_state_t KVT_STATE_RESET = '{
        byte_position:      '0,
        line_count:         16'd1,
        scan_mode:          MODE_SKIP,
        token_begin:        '0,
        token_line:         16'd1,
        previous_was_quote: 1'b0,
        pending_quote:      1'b0,
        saved_key_offset:   '0,
        saved_key_length:   '0,
        expect_value:       1'b0,
        error_seen:         1'b0
    };

endpackage

`default_nettype wire

@@ src/kvt_step.sv @@
`default_nettype none

// Next-state and result logic for one text byte.
module kvt_step
    import kvt_pkg::*;
#(
    parameter int BUFFER_BYTES = KVT_BUFFER_BYTES_DEFAULT
) (
    input  wire kvt_state_t  cur,
    input  wire logic [7:0]  text_byte,
    output kvt_state_t       nxt,
    output kvt_result_t      res,
    output logic             emit
);

    localparam int OFS_LIMIT = (BUFFER_BYTES < 4096) ? BUFFER_BYTES : 4096;
    localparam int OFS_CAP   = OFS_LIMIT - 1;
    localparam logic [POS_W-1:0] LIMIT_P = POS_W'(OFS_LIMIT);
    localparam logic [POS_W-1:0] CAP_P   = POS_W'(OFS_CAP);

    logic [POS_W-1:0] p;
    logic [POS_W-1:0] p_inc;
    logic [POS_W-1:0] p_dec;
    logic [OFS_W-1:0] off;
    logic [OFS_W-1:0] q_begin;
    logic [OFS_W-1:0] close_end;
    logic             overflow;
    logic             do_finish;
    logic             do_start;
    logic             set_error;
    logic             pair;
    logic             buf_end;
    logic [OFS_W-1:0] fin_end;
    logic [OFS_W-1:0] fin_len;

    always_comb
    begin
        overflow  = (cur.byte_position >= LIMIT_P);
        p         = overflow ? LIMIT_P : cur.byte_position;
        off       = (p > CAP_P) ? CAP_P[OFS_W-1:0] : p[OFS_W-1:0];
        p_inc     = p + POS_W'(1);
        q_begin   = (p_inc > CAP_P) ? CAP_P[OFS_W-1:0] : p_inc[OFS_W-1:0];
        p_dec     = (p != '0) ? (p - POS_W'(1)) : '0;
        close_end = (p_dec > CAP_P) ? CAP_P[OFS_W-1:0] : p_dec[OFS_W-1:0];

        nxt       = cur;
        do_finish = 1'b0;
        do_start  = 1'b0;
        set_error = 1'b0;
        fin_end   = off;
        pair      = 1'b0;
        buf_end   = 1'b0;
        res       = '0;

        case (cur.scan_mode)
            MODE_WORD:
            begin
                if (text_byte == CH_BLANK || text_byte == CH_TAB || text_byte == CH_EOL ||
                    text_byte == CH_EQ || text_byte == CH_NUL)
                begin
                    do_finish     = 1'b1;
                    nxt.scan_mode = MODE_SKIP;
                    do_start      = 1'b1;
                end
            end
            MODE_QFIRST:
            begin
                if (text_byte == CH_QUOTE)
                begin
                    do_finish     = 1'b1;
                    fin_end       = cur.token_begin;
                    nxt.scan_mode = MODE_SKIP;
                end
                else if (text_byte == CH_EOL || text_byte == CH_NUL)
                begin
                    set_error     = 1'b1;
                    do_finish     = 1'b1;
                    nxt.scan_mode = MODE_SKIP;
                    do_start      = 1'b1;
                end
                else
                begin
                    nxt.scan_mode          = MODE_QBODY;
                    nxt.previous_was_quote = 1'b0;
                    nxt.pending_quote      = 1'b0;
                end
            end
            MODE_QBODY:
            begin
                if (cur.pending_quote)
                begin
                    nxt.pending_quote = 1'b0;
                    if (text_byte == CH_QUOTE)
                    begin
                        nxt.previous_was_quote = 1'b1;
                    end
                    else
                    begin
                        do_finish              = 1'b1;
                        fin_end                = close_end;
                        nxt.scan_mode          = MODE_SKIP;
                        nxt.previous_was_quote = 1'b0;
                        do_start               = 1'b1;
                    end
                end
                else if (text_byte == CH_QUOTE)
                begin
                    if (!cur.previous_was_quote)
                    begin
                        nxt.pending_quote = 1'b1;
                    end
                end
                else if (text_byte == CH_EOL || text_byte == CH_NUL)
                begin
                    set_error              = 1'b1;
                    do_finish              = 1'b1;
                    nxt.scan_mode          = MODE_SKIP;
                    nxt.previous_was_quote = 1'b0;
                    do_start               = 1'b1;
                end
                else
                begin
                    nxt.previous_was_quote = 1'b0;
                end
            end
            default:
            begin
                nxt.scan_mode = MODE_SKIP;
                do_start      = 1'b1;
            end
        endcase

        // A finished token either completes a pair or becomes the saved key.
        fin_len = (fin_end > cur.token_begin) ? (fin_end - cur.token_begin) : '0;
        if (do_finish)
        begin
            if (cur.expect_value)
            begin
                nxt.expect_value = 1'b0;
                pair             = 1'b1;
                res.pair_valid   = 1'b1;
                res.key_offset   = cur.saved_key_offset;
                res.key_length   = cur.saved_key_length;
                res.value_offset = cur.token_begin;
                res.value_length = fin_len;
                res.line_number  = cur.token_line;
            end
            else
            begin
                nxt.saved_key_offset = cur.token_begin;
                nxt.saved_key_length = fin_len;
            end
        end

        // Skip-mode bytes and non-quote token enders are looked at here.
        if (do_start)
        begin
            if (text_byte == CH_BLANK || text_byte == CH_TAB)
            begin
                nxt.line_count = nxt.line_count;
            end
            else if (text_byte == CH_EOL)
            begin
                if (cur.line_count != {LINE_W{1'b1}})
                begin
                    nxt.line_count = cur.line_count + LINE_W'(1);
                end
            end
            else if (text_byte == CH_EQ)
            begin
                nxt.expect_value = 1'b1;
            end
            else if (text_byte == CH_NUL)
            begin
                buf_end = 1'b1;
            end
            else
            begin
                nxt.token_line = cur.line_count;
                if (text_byte == CH_QUOTE)
                begin
                    nxt.scan_mode   = MODE_QFIRST;
                    nxt.token_begin = q_begin;
                end
                else
                begin
                    nxt.scan_mode   = MODE_WORD;
                    nxt.token_begin = off;
                end
            end
        end

        nxt.error_seen    = cur.error_seen | overflow | set_error;
        nxt.byte_position = (p < LIMIT_P) ? p_inc : LIMIT_P;

        if (buf_end)
        begin
            if (!pair)
            begin
                res.line_number = nxt.line_count;
            end
            res.buffer_end = 1'b1;
            res.had_error  = nxt.error_seen;
            nxt            = KVT_STATE_RESET;
        end

        emit = pair | buf_end;
    end

endmodule

`default_nettype wire

@@ src/keyword_value_pair_tokenizer_core.sv @@
// An accepted byte waits in the input register; when the scan step takes it, its result,
// if it makes one, is written to the result register and out_valid rises.
// Throughput: one byte per cycle while the input is not stalled; the whole scan step is one pass of logic between
// the input register and the result register. A byte that makes no result never waits;
// a byte that makes one waits while the held result is not taken, which stalls the input.
// Reset (rst_n low, asynchronous) empties both registers, sets position to 0, line to 1.
`default_nettype none

module keyword_value_pair_tokenizer_core
    import kvt_pkg::*;
#(
    parameter int BUFFER_BYTES = KVT_BUFFER_BYTES_DEFAULT
) (
    input  wire logic              clk,
    input  wire logic              rst_n,

    input  wire logic              in_valid,
    output logic                   in_ready,
    input  wire logic [7:0]        text_byte,

    output logic                   out_valid,
    input  wire logic              out_ready,
    output logic                   pair_valid,
    output logic [OFS_W-1:0]       key_offset,
    output logic [OFS_W-1:0]       key_length,
    output logic [OFS_W-1:0]       value_offset,
    output logic [OFS_W-1:0]       value_length,
    output logic [LINE_W-1:0]      line_number,
    output logic                   buffer_end,
    output logic                   had_error
);

    // Scanner state: position, line count, token bookkeeping and the saved key.
    kvt_state_t  state_reg;
    kvt_state_t  state_next;

    // Input register holds one accepted byte until the scan step consumes it.
    logic        in_vld_reg;
    logic [7:0]  byte_reg;

    // Result register holds one finished transaction for the output side.
    logic        out_vld_reg;
    kvt_result_t res_reg;

    kvt_result_t step_res;
    logic        step_emit;
    logic        step_go;

    kvt_step #(
        .BUFFER_BYTES (BUFFER_BYTES)
    ) u_step (
        .cur       (state_reg),
        .text_byte (byte_reg),
        .nxt       (state_next),
        .res       (step_res),
        .emit      (step_emit)
    );

    // The buffered byte is processed when its result (if it makes one) has a place to go.
    // A byte that makes no result never waits on the output side.
    assign step_go  = in_vld_reg && (!out_vld_reg || out_ready || !step_emit);
    assign in_ready = !in_vld_reg || step_go;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg   <= KVT_STATE_RESET;
            in_vld_reg  <= 1'b0;
            out_vld_reg <= 1'b0;
        end
        else
        begin
            if (step_go)
            begin
                state_reg <= state_next;
            end

            if (in_valid && in_ready)
            begin
                in_vld_reg <= 1'b1;
            end
            else if (step_go)
            begin
                in_vld_reg <= 1'b0;
            end

            if (step_go && step_emit)
            begin
                out_vld_reg <= 1'b1;
            end
            else if (out_ready)
            begin
                out_vld_reg <= 1'b0;
            end
        end
    end

    // Payload registers carry no reset; their valid flags guard them.
    always_ff @(posedge clk)
    begin
        if (in_valid && in_ready)
        begin
            byte_reg <= text_byte;
        end
        if (step_go && step_emit)
        begin
            res_reg <= step_res;
        end
    end

    assign out_valid    = out_vld_reg;
    assign pair_valid   = res_reg.pair_valid;
    assign key_offset   = res_reg.key_offset;
    assign key_length   = res_reg.key_length;
    assign value_offset = res_reg.value_offset;
    assign value_length = res_reg.value_length;
    assign line_number  = res_reg.line_number;
    assign buffer_end   = res_reg.buffer_end;
    assign had_error    = res_reg.had_error;

endmodule

`default_nettype wire
